// ===== rtl/core/cdcr_pkg.sv =====
// Package of the color display control register bank.
// Holds the command codes, register offsets, word types and the wrap helpers.
// No dependencies.
package cdcr_pkg;

	localparam int unsigned SYNC_RAM_DEPTH_DEF  = 4096;
	localparam int unsigned PALETTE_ENTRIES_DEF = 64;

	// Wrap helpers are exact only for depths of at least 256 sync entries and 16 palette entries.
	localparam int unsigned SYNC_WRAP_STEPS = 4;
	localparam int unsigned PAL_WRAP_STEPS  = 2;

	typedef logic [7:0]  sync_word_t;
	typedef logic [23:0] color_t;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_IRQ   = 2'd2
	} command_t;

	localparam logic [2:0] OFF_MODE    = 3'd0;
	localparam logic [2:0] OFF_SYNC    = 3'd1;
	localparam logic [2:0] OFF_POINTER = 3'd2;
	localparam logic [2:0] OFF_SPACING = 3'd3;
	localparam logic [2:0] OFF_PALETTE = 3'd4;

	localparam logic [1:0] CHAN_RED   = 2'd0;
	localparam logic [1:0] CHAN_GREEN = 2'd1;
	localparam logic [1:0] CHAN_BLUE  = 2'd2;

	localparam int unsigned MODE_IRQ_EN  = 3;
	localparam int unsigned MODE_IRQ_REQ = 4;

	// Reduces a 12-bit pointer modulo m by a short chain of compare and subtract.
	function automatic logic [11:0] wrap_sync(logic [11:0] v, int unsigned m);
		logic [15:0] r;
		logic [15:0] step;
		r = {4'b0, v};
		for (int k = SYNC_WRAP_STEPS - 1; k >= 0; k--) begin
			step = 16'(m << k);
			if (r >= step) begin
				r = r - step;
			end
		end
		return r[11:0];
	endfunction

	// Reduces a 6-bit entry number modulo m.
	function automatic logic [5:0] wrap_pal(logic [5:0] v, int unsigned m);
		logic [7:0] r;
		logic [7:0] step;
		r = {2'b0, v};
		for (int k = PAL_WRAP_STEPS - 1; k >= 0; k--) begin
			step = 8'(m << k);
			if (r >= step) begin
				r = r - step;
			end
		end
		return r[5:0];
	endfunction

endpackage

// ===== rtl/core/cdcr_sync_ram.sv =====
// Sync RAM of the color display control register bank, with a clearing pass.
// One write port, one registered read port with write bypass.
// Depends on cdcr_pkg.
module cdcr_sync_ram #(
	parameter int unsigned DEPTH = cdcr_pkg::SYNC_RAM_DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 clearing,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  cdcr_pkg::sync_word_t wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output cdcr_pkg::sync_word_t rd_data
);
	import cdcr_pkg::*;

	sync_word_t          mem_q [DEPTH];
	logic                clr_busy_q;
	logic [AW-1:0]       clr_addr_q;
	sync_word_t          rd_data_q;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	sync_word_t          mem_wdata;

	// After reset every entry is written with zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_comb begin
		mem_we    = clr_busy_q | wr_en;
		mem_waddr = clr_busy_q ? clr_addr_q : wr_addr;
		mem_wdata = clr_busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	// A write in the same cycle to the same entry is passed straight through.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem_q[rd_addr];
			end
		end
	end

	assign clearing = clr_busy_q;
	assign rd_data  = rd_data_q;

endmodule

// ===== rtl/core/cdcr_palette.sv =====
// Palette memory of the color display control register bank.
// One write port, two registered read ports with write bypass, per-entry valid bits.
// Depends on cdcr_pkg.
module cdcr_palette #(
	parameter int unsigned ENTRIES = cdcr_pkg::PALETTE_ENTRIES_DEF,
	localparam int unsigned IW = $clog2(ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IW-1:0]    wr_addr,
	input  cdcr_pkg::color_t wr_data,
	input  logic             rd_en,
	input  logic [IW-1:0]    rd_addr_a,
	input  logic [IW-1:0]    rd_addr_b,
	output cdcr_pkg::color_t rd_data_a,
	output cdcr_pkg::color_t rd_data_b
);
	import cdcr_pkg::*;

	color_t              mem_q [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	color_t              rd_a_q;
	color_t              rd_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// An entry never written since reset reads as black level zero.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr_a)) begin
				rd_a_q <= wr_data;
			end else if (valid_q[rd_addr_a]) begin
				rd_a_q <= mem_q[rd_addr_a];
			end else begin
				rd_a_q <= '0;
			end
			if (wr_en && (wr_addr == rd_addr_b)) begin
				rd_b_q <= wr_data;
			end else if (valid_q[rd_addr_b]) begin
				rd_b_q <= mem_q[rd_addr_b];
			end else begin
				rd_b_q <= '0;
			end
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ===== rtl/core/color_display_control_registers_core.sv =====
// Top level of the color display control register bank.
// Instantiates cdcr_sync_ram and cdcr_palette; depends on cdcr_pkg.
//
// Usage: the input channel carries one bus word per handshake: a register read,
// a register write or an interrupt request event, together with the current
// sync levels and the palette entry the display side wants. The output channel
// returns one word for every input word: read data, bus error, interrupt status,
// the sync PROM flag and the 24-bit palette color after the word's own update.
// An accepted word is held in an input stage, where the sync RAM and palette reads
// for it land; its result is registered from there into the result register.
// One word can be taken every cycle while the receiver does not stall, set by
// the single read-modify-write pass through the palette and sync RAM ports.
// After reset the sync RAM is cleared one entry per cycle, through all SYNC_RAM_DEPTH
// entries (4096 by default); in_stall stays high until that pass is done.
// The palette comes out of reset all zero at once.
// When the receiver stalls, the result is held, the input stage holds its word
// and in_stall rises in the same cycle, so no word is lost or repeated.
module color_display_control_registers_core #(
	parameter int unsigned SYNC_RAM_DEPTH  = cdcr_pkg::SYNC_RAM_DEPTH_DEF,
	parameter int unsigned PALETTE_ENTRIES = cdcr_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  offset,
	input  logic [15:0] write_data,
	input  logic        hsync,
	input  logic        vsync,
	input  logic [5:0]  palette_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        bus_error,
	output logic        interrupt_raised,
	output logic        interrupt_enabled,
	output logic        sync_prom_enabled,
	output logic [23:0] palette_color
);
	import cdcr_pkg::*;

	localparam int unsigned SA_W = $clog2(SYNC_RAM_DEPTH);
	localparam int unsigned PI_W = $clog2(PALETTE_ENTRIES);

	// Input stage.
	logic            valid_s1;
	command_t        cmd_s1;
	logic [2:0]      off_s1;
	logic [15:0]     wdata_s1;
	logic            hs_s1;
	logic            vs_s1;
	logic [PI_W-1:0] pidx_s1;
	logic [PI_W-1:0] pent_s1;
	logic [SA_W-1:0] sslot_s1;

	// Architectural state.
	logic [4:0]      mode_q;
	logic            prom_q;
	logic [SA_W-1:0] sync_slot_q;

	// Result register.
	logic            out_valid_q;
	logic [7:0]      read_data_q;
	logic            bus_error_q;
	logic            raised_q;
	logic            irq_en_q;
	logic            prom_out_q;
	color_t          color_q;

	logic            advance;
	logic            accept;
	logic            clearing;
	logic [PI_W-1:0] in_pent;
	logic [PI_W-1:0] in_pidx;
	logic [SA_W-1:0] in_sslot;
	logic [SA_W-1:0] sync_raddr;
	sync_word_t      sync_rdata;
	color_t          pal_entry_rd;
	color_t          pal_index_rd;

	logic [7:0]      rd_c;
	logic            err_c;
	logic            raised_c;
	logic [4:0]      mode_c;
	logic            prom_c;
	logic            slot_load_c;
	logic            sync_we_c;
	logic            pal_we_c;
	color_t          pal_next_c;
	color_t          color_c;
	logic [7:0]      level_c;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clearing || (valid_s1 && !advance);
	assign accept   = in_valid && !in_stall;

	assign in_pent  = PI_W'(wrap_pal(write_data[5:0], PALETTE_ENTRIES));
	assign in_pidx  = PI_W'(wrap_pal(palette_index, PALETTE_ENTRIES));
	assign in_sslot = SA_W'(wrap_sync(write_data[11:0], SYNC_RAM_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= command_t'(command);
			off_s1   <= offset;
			wdata_s1 <= write_data;
			hs_s1    <= hsync;
			vs_s1    <= vsync;
			pidx_s1  <= in_pidx;
			pent_s1  <= in_pent;
			sslot_s1 <= in_sslot;
		end
	end

	// The word in the input stage is executed against the current state.
	always_comb begin
		rd_c        = '0;
		err_c       = 1'b0;
		raised_c    = 1'b0;
		mode_c      = mode_q;
		prom_c      = prom_q;
		slot_load_c = 1'b0;
		sync_we_c   = 1'b0;
		pal_we_c    = 1'b0;
		level_c     = ~wdata_s1[15:8];
		pal_next_c  = pal_entry_rd;
		unique case (cmd_s1)
			CMD_READ: begin
				unique case (off_s1)
					OFF_MODE: rd_c = {prom_q, hs_s1, vs_s1, mode_q};
					OFF_SYNC: rd_c = prom_q ? 8'h00 : sync_rdata;
					default:  err_c = 1'b1;
				endcase
			end
			CMD_WRITE: begin
				unique case (off_s1)
					OFF_MODE:    mode_c = wdata_s1[4:0];
					OFF_SYNC:    sync_we_c = !prom_q;
					OFF_POINTER: slot_load_c = 1'b1;
					OFF_SPACING: prom_c = !wdata_s1[7];
					OFF_PALETTE: begin
						unique case (wdata_s1[7:6])
							CHAN_RED: begin
								pal_we_c   = 1'b1;
								pal_next_c = {level_c, pal_entry_rd[15:0]};
							end
							CHAN_GREEN: begin
								pal_we_c   = 1'b1;
								pal_next_c = {pal_entry_rd[23:16], level_c, pal_entry_rd[7:0]};
							end
							CHAN_BLUE: begin
								pal_we_c   = 1'b1;
								pal_next_c = {pal_entry_rd[23:8], level_c};
							end
							default: pal_we_c = 1'b0;
						endcase
					end
					default: err_c = 1'b1;
				endcase
			end
			CMD_IRQ: begin
				if (mode_q[MODE_IRQ_EN]) begin
					mode_c[MODE_IRQ_REQ] = 1'b1;
					raised_c             = 1'b1;
				end
			end
			default: err_c = 1'b0;
		endcase
		// The display-side read sees this word's own palette update.
		if (pal_we_c && (pent_s1 == pidx_s1)) begin
			color_c = pal_next_c;
		end else begin
			color_c = pal_index_rd;
		end
	end

	// The next word's sync read follows a pointer load by the retiring word.
	assign sync_raddr = (advance && slot_load_c) ? sslot_s1 : sync_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			prom_q      <= 1'b0;
			sync_slot_q <= '0;
		end else if (advance) begin
			mode_q <= mode_c;
			prom_q <= prom_c;
			if (slot_load_c) begin
				sync_slot_q <= sslot_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_c;
			bus_error_q <= err_c;
			raised_q    <= raised_c;
			irq_en_q    <= mode_c[MODE_IRQ_EN];
			prom_out_q  <= prom_c;
			color_q     <= color_c;
		end
	end

	cdcr_sync_ram #(
		.DEPTH(SYNC_RAM_DEPTH)
	) u_sync_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.wr_en    (advance && sync_we_c),
		.wr_addr  (sync_slot_q),
		.wr_data  (wdata_s1[7:0]),
		.rd_en    (accept),
		.rd_addr  (sync_raddr),
		.rd_data  (sync_rdata)
	);

	cdcr_palette #(
		.ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance && pal_we_c),
		.wr_addr   (pent_s1),
		.wr_data   (pal_next_c),
		.rd_en     (accept),
		.rd_addr_a (in_pent),
		.rd_addr_b (in_pidx),
		.rd_data_a (pal_entry_rd),
		.rd_data_b (pal_index_rd)
	);

	assign out_valid         = out_valid_q;
	assign read_data         = read_data_q;
	assign bus_error         = bus_error_q;
	assign interrupt_raised  = raised_q;
	assign interrupt_enabled = irq_en_q;
	assign sync_prom_enabled = prom_out_q;
	assign palette_color     = color_q;

	// A faulted access never returns data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bus_error_q |-> read_data_q == 8'h00)
		else $error("bus error result carries read data");

	// An interrupt can only be raised while interrupts stay enabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && raised_q |-> irq_en_q)
		else $error("interrupt raised with interrupts disabled");

	// No result can appear while the sync RAM is still being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid_q && !valid_s1)
		else $error("word in flight during sync RAM clear");

	// A result is produced only from a word that sat in the input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result without a word in the input stage");

endmodule

// ===== bench/tb_color_display_control_registers_core.sv =====
// Self-checking testbench for the color display control register bank.
// Drives bus words with random idling and stalls, and checks every result against its own
// prediction of the bank. Depends on cdcr_pkg and color_display_control_registers_core.
module tb_color_display_control_registers_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cdcr_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [2:0] OFF_LAST = 3'd7;
	localparam logic [1:0] CHAN_SPARE = 2'd3;
	localparam int unsigned RANDOM_WORDS = 925;
	localparam int unsigned QUIET_AFTER = 800;
	localparam int unsigned PRESSURE_AT = 300;
	localparam int unsigned LONG_HOLD_CYCLES = 150;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] rdata;
		logic       berr;
		logic       raised;
		logic       irq_en;
		logic       prom;
		color_t     color;
	} bank_status_t;

	// Tracks the register bank and the queue of results it still owes.
	class bank_scoreboard;
		logic [4:0]  mode;
		logic        prom;
		logic [6:0]  spacing;
		logic [11:0] sync_ptr;
		sync_word_t  sync_mem[SYNC_RAM_DEPTH_DEF];
		color_t      palette[PALETTE_ENTRIES_DEF];
		bank_status_t owed[$];
		int unsigned mismatches;
		int unsigned words_in;
		int unsigned words_checked;

		function new();
			mode = '0;
			prom = 1'b0;
			spacing = '0;
			sync_ptr = '0;
			foreach (sync_mem[i]) sync_mem[i] = '0;
			foreach (palette[i]) palette[i] = '0;
			mismatches = 0;
			words_in = 0;
			words_checked = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		function int unsigned pending();
			return owed.size();
		endfunction

		// Applies one accepted bus word and queues the status it must produce.
		function void note_word(logic [1:0] cmd, logic [2:0] off, logic [15:0] wd,
				logic hs, logic vs, logic [5:0] pidx);
			bank_status_t r;
			logic [7:0] level;
			r = '0;
			level = ~wd[15:8];
			case (cmd)
				CMD_READ: begin
					if (off == OFF_MODE) begin
						r.rdata = {prom, hs, vs, mode};
					end else if (off == OFF_SYNC) begin
						r.rdata = prom ? 8'd0 : sync_mem[sync_ptr];
					end else begin
						r.berr = 1'b1;
					end
				end
				CMD_WRITE: begin
					case (off)
						OFF_MODE: mode = wd[4:0];
						OFF_SYNC: if (!prom) sync_mem[sync_ptr] = wd[7:0];
						OFF_POINTER: sync_ptr = wd[11:0];
						OFF_SPACING: begin
							prom = ~wd[7];
							spacing = wd[6:0];
						end
						OFF_PALETTE: begin
							case (wd[7:6])
								CHAN_RED: palette[wd[5:0]][23:16] = level;
								CHAN_GREEN: palette[wd[5:0]][15:8] = level;
								CHAN_BLUE: palette[wd[5:0]][7:0] = level;
								default: ;
							endcase
						end
						default: r.berr = 1'b1;
					endcase
				end
				CMD_IRQ: begin
					if (mode[MODE_IRQ_EN]) begin
						mode[MODE_IRQ_REQ] = 1'b1;
						r.raised = 1'b1;
					end
				end
				default: ;
			endcase
			r.irq_en = mode[MODE_IRQ_EN];
			r.prom = prom;
			r.color = palette[pidx];
			owed.push_back(r);
			words_in++;
		endfunction

		task check_word(bank_status_t got);
			bank_status_t want;
			if (owed.size() == 0) begin
				report("result word arrived with nothing outstanding");
				return;
			end
			want = owed.pop_front();
			words_checked++;
			if (got.rdata !== want.rdata)
				report($sformatf("read_data %0h, expected %0h", got.rdata, want.rdata));
			if (got.berr !== want.berr)
				report($sformatf("bus_error %0b, expected %0b", got.berr, want.berr));
			if (got.raised !== want.raised)
				report($sformatf("interrupt_raised %0b, expected %0b",
					got.raised, want.raised));
			if (got.irq_en !== want.irq_en)
				report($sformatf("interrupt_enabled %0b, expected %0b",
					got.irq_en, want.irq_en));
			if (got.prom !== want.prom)
				report($sformatf("sync_prom_enabled %0b, expected %0b", got.prom, want.prom));
			if (got.color !== want.color)
				report($sformatf("palette_color %06h, expected %06h", got.color, want.color));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [2:0]  offset;
	logic [15:0] write_data;
	logic        hsync;
	logic        vsync;
	logic [5:0]  palette_index;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        bus_error;
	logic        interrupt_raised;
	logic        interrupt_enabled;
	logic        sync_prom_enabled;
	logic [23:0] palette_color;

	bank_scoreboard book;
	bit quiet_tail = 1'b0;
	bit long_hold_req = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned words_sent = 0;

	color_display_control_registers_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.offset(offset),
		.write_data(write_data),
		.hsync(hsync),
		.vsync(vsync),
		.palette_index(palette_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.bus_error(bus_error),
		.interrupt_raised(interrupt_raised),
		.interrupt_enabled(interrupt_enabled),
		.sync_prom_enabled(sync_prom_enabled),
		.palette_color(palette_color)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// Offers one word, possibly after an idle burst, and returns at the edge it is taken.
	task automatic send_word(logic [1:0] cmd, logic [2:0] off, logic [15:0] wd,
			logic hs, logic vs, logic [5:0] pidx);
		if (!quiet_tail && $urandom_range(1, 100) <= send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		command <= cmd;
		offset <= off;
		write_data <= wd;
		hsync <= hs;
		vsync <= vs;
		palette_index <= pidx;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		book.note_word(cmd, off, wd, hs, vs, pidx);
		words_sent++;
		if (words_sent % 64 == 0) send_idle_pct = pick_idle_pct();
	endtask

	task automatic send_rand_status(logic [1:0] cmd, logic [2:0] off, logic [15:0] wd);
		send_word(cmd, off, wd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			6'($urandom_range(0, 63)));
	endtask

	task automatic run_directed();
		send_word(CMD_READ, OFF_MODE, 16'h0000, 1'b0, 1'b0, 6'd0);
		send_word(CMD_READ, OFF_SYNC, 16'hFFFF, 1'b1, 1'b1, 6'd63);
		send_word(CMD_WRITE, OFF_MODE, 16'hFFFF, 1'b0, 1'b1, 6'd1);
		send_word(CMD_READ, OFF_MODE, 16'h0000, 1'b1, 1'b1, 6'd0);
		send_word(CMD_IRQ, OFF_MODE, 16'h0000, 1'b0, 1'b0, 6'd0);
		send_word(CMD_WRITE, OFF_MODE, 16'h0000, 1'b1, 1'b0, 6'd0);
		// An interrupt event with the enable bit clear must leave everything alone.
		send_word(CMD_IRQ, OFF_MODE, 16'hFFFF, 1'b0, 1'b0, 6'd0);
		send_word(CMD_WRITE, OFF_POINTER, 16'hFFFF, 1'b0, 1'b0, 6'd0);
		send_word(CMD_WRITE, OFF_SYNC, 16'hFFA5, 1'b0, 1'b0, 6'd0);
		send_word(CMD_READ, OFF_SYNC, 16'h0000, 1'b0, 1'b0, 6'd0);
		send_word(CMD_WRITE, OFF_SPACING, 16'h0000, 1'b0, 1'b0, 6'd0);
		send_word(CMD_READ, OFF_SYNC, 16'h0000, 1'b0, 1'b0, 6'd0);
		send_word(CMD_WRITE, OFF_SYNC, 16'h005A, 1'b0, 1'b0, 6'd0);
		send_word(CMD_READ, OFF_MODE, 16'h0000, 1'b0, 1'b0, 6'd0);
		send_word(CMD_WRITE, OFF_SPACING, 16'hFFFF, 1'b0, 1'b0, 6'd0);
		send_word(CMD_READ, OFF_SYNC, 16'h0000, 1'b0, 1'b0, 6'd0);
		send_word(CMD_WRITE, OFF_PALETTE, {8'h00, CHAN_RED, 6'd63}, 1'b0, 1'b0, 6'd63);
		send_word(CMD_WRITE, OFF_PALETTE, {8'hFF, CHAN_GREEN, 6'd63}, 1'b0, 1'b0, 6'd63);
		send_word(CMD_WRITE, OFF_PALETTE, {8'h5C, CHAN_BLUE, 6'd0}, 1'b0, 1'b0, 6'd0);
		send_word(CMD_WRITE, OFF_PALETTE, {8'h00, CHAN_SPARE, 6'd63}, 1'b0, 1'b0, 6'd63);
		for (int o = OFF_POINTER; o <= OFF_LAST; o++) begin
			send_word(CMD_READ, 3'(o), 16'hFFFF, 1'b1, 1'b1, 6'd63);
		end
		for (int o = OFF_PALETTE + 1; o <= OFF_LAST; o++) begin
			send_word(CMD_WRITE, 3'(o), 16'hFFFF, 1'b1, 1'b1, 6'd63);
		end
		send_word(CMD_SPARE, OFF_MODE, 16'hFFFF, 1'b1, 1'b1, 6'd63);
	endtask

	// Mostly short well-formed access sequences, with some fully random noise words.
	task automatic run_random(int unsigned count);
		int unsigned stop_at;
		logic [11:0] addr;
		logic [5:0]  entry;
		logic [15:0] wd;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			if (words_sent >= PRESSURE_AT && words_sent < PRESSURE_AT + 4 && !long_hold_req)
				long_hold_req = 1'b1;
			if (words_sent >= QUIET_AFTER) quiet_tail = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// A small pool of addresses near both ends makes reads hit earlier writes.
					if ($urandom_range(0, 3) == 0) addr = 12'($urandom_range(0, 4095));
					else if ($urandom_range(0, 1) == 0) addr = 12'($urandom_range(0, 15));
					else addr = 12'hFFF - 12'($urandom_range(0, 15));
					send_rand_status(CMD_WRITE, OFF_POINTER, {4'($urandom_range(0, 15)), addr});
					if ($urandom_range(0, 2) != 0)
						send_rand_status(CMD_WRITE, OFF_SYNC, 16'($urandom_range(0, 65535)));
					send_rand_status(CMD_READ, OFF_SYNC, 16'($urandom_range(0, 65535)));
				end
				3, 4: begin
					entry = 6'($urandom_range(0, 63));
					wd = {8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), entry};
					send_rand_status(CMD_WRITE, OFF_PALETTE, wd);
					send_word(CMD_READ, OFF_MODE, 16'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), entry);
				end
				5: begin
					send_rand_status(CMD_WRITE, OFF_MODE, 16'($urandom_range(0, 65535)));
					send_rand_status(CMD_IRQ, 3'($urandom_range(0, 7)),
						16'($urandom_range(0, 65535)));
					send_rand_status(CMD_READ, OFF_MODE, 16'($urandom_range(0, 65535)));
				end
				6: begin
					wd = 16'($urandom_range(0, 65535));
					wd[7] = ($urandom_range(0, 3) != 0);
					send_rand_status(CMD_WRITE, OFF_SPACING, wd);
				end
				7: send_rand_status(CMD_READ, 3'($urandom_range(0, 7)),
					16'($urandom_range(0, 65535)));
				default: send_rand_status(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
					16'($urandom_range(0, 65535)));
			endcase
		end
	endtask

	initial begin
		book = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_READ;
		offset <= OFF_MODE;
		write_data <= '0;
		hsync <= 1'b0;
		vsync <= 1'b0;
		palette_index <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		send_idle_pct = pick_idle_pct();
		run_random(RANDOM_WORDS);
		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d bus words (reads, writes, interrupt events, bad offsets),",
			book.words_in);
		$display("%0d result words checked, %0d mismatches.", book.words_checked,
			book.mismatches);
		if (book.mismatches == 0) begin
			$display("color_display_control_registers_core verification clean");
		end else begin
			$display("color_display_control_registers_core verification failed");
		end
		$finish;
	end

	// Receiver side: random stall bursts, one or more long hold-offs, and none in the tail.
	initial begin : receiver
		int unsigned pct;
		int unsigned until_repick;
		pct = 0;
		until_repick = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (until_repick == 0) begin
				pct = pick_idle_pct();
				until_repick = 200;
			end
			until_repick--;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(1, 100) <= pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		bank_status_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.rdata = read_data;
			seen.berr = bus_error;
			seen.raised = interrupt_raised;
			seen.irq_en = interrupt_enabled;
			seen.prom = sync_prom_enabled;
			seen.color = palette_color;
			book.check_word(seen);
		end
	end

	initial begin
		#2000000;
		$display("Timed out with %0d result words outstanding.", book.pending());
		$display("color_display_control_registers_core verification failed");
		$finish;
	end

endmodule
